>>> sv/assert_macros.svh
// assertion macros for the rtl file that carries checks
// no dependencies; clock clk and reset arst_n must be in scope at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen on a rising edge of clk outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> sv/crcfd_pkg.sv
// types, codes and the crc byte update for the crc16 frame deframer
// no dependencies
package crcfd_pkg;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD_VALUE      = 3'd0,
		REG_LENGTH_OFFSET   = 3'd1,
		REG_HEADER_LENGTH   = 3'd2,
		REG_OVERHEAD_LENGTH = 3'd3,
		REG_MAX_DATA_LENGTH = 3'd4,
		REG_CRC_START       = 3'd5,
		REG_CRC_INIT        = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_HUNT   = 2'd0,
		PH_HEADER = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_GOOD    = 2'd1,
		ST_BAD_CRC = 2'd2,
		ST_REJECT  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  head_value;
		logic [3:0]  length_offset;
		logic [3:0]  header_length;
		logic [4:0]  overhead_length;
		logic [7:0]  max_data_length;
		logic [3:0]  crc_start;
		logic [15:0] crc_init;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] frame_byte;
		logic [7:0] byte_index;
		logic       frame_last;
		status_t    frame_status;
	} res_t;

	localparam cfg_t CFG_RESET = '{
		head_value:      8'd0,
		length_offset:   4'd2,
		header_length:   4'd3,
		overhead_length: 5'd5,
		max_data_length: 8'd64,
		crc_start:       4'd1,
		crc_init:        16'h0000
	};

	// msb-first crc16 over one byte
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> sv/crcfd_if.sv
// request channels of the crc16 frame deframer: received bytes in, frame bytes out
// no dependencies
interface crcfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfd_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic [7:0] byte_index;
	logic       frame_last;
	logic [1:0] frame_status;

	modport source (output valid, output frame_byte, output byte_index,
		output frame_last, output frame_status, input ready);
	modport sink (input valid, input frame_byte, input byte_index,
		input frame_last, input frame_status, output ready);
endinterface

>>> sv/crcfd_cfg_regs.sv
// configuration registers of the crc16 frame deframer
// depends on crcfd_pkg
module crcfd_cfg_regs
	import crcfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_HEAD_VALUE:      cfg_q.head_value      <= cfg_wdata[7:0];
				REG_LENGTH_OFFSET:   cfg_q.length_offset   <= cfg_wdata[3:0];
				REG_HEADER_LENGTH:   cfg_q.header_length   <= cfg_wdata[3:0];
				REG_OVERHEAD_LENGTH: cfg_q.overhead_length <= cfg_wdata[4:0];
				REG_MAX_DATA_LENGTH: cfg_q.max_data_length <= cfg_wdata[7:0];
				REG_CRC_START:       cfg_q.crc_start       <= cfg_wdata[3:0];
				REG_CRC_INIT:        cfg_q.crc_init        <= cfg_wdata[15:0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/crcfd_parser.sv
// frame parser: phase, byte count, length, running crc and the result of one byte
// depends on crcfd_pkg
module crcfd_parser
	import crcfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output res_t       res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  dlen_q, dlen_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_hi_q, crc_hi_d;
	logic        match_q, match_d;

	logic        start, active, in_hdr, at_len, reject, last_reach, ends;
	logic [7:0]  idx, dlen_cur, hi_cur, dlen_eff;
	logic [15:0] crc_cur;
	logic        match_cur, crc_on;
	logic [8:0]  total_rx, crc_pos, crc_pos_p1, total, last_pos;

	assign start    = !(phase_q == PH_HEADER || phase_q == PH_DATA);
	assign active   = !start || (rx_byte == cfg.head_value);
	assign in_hdr   = start || (phase_q == PH_HEADER);
	assign idx      = start ? 8'd0 : count_q;
	assign crc_cur  = start ? cfg.crc_init : crc_q;
	assign dlen_cur = start ? 8'd0 : dlen_q;
	assign hi_cur   = start ? 8'd0 : crc_hi_q;
	assign match_cur = start ? 1'b0 : match_q;

	assign at_len   = in_hdr && (idx == {4'd0, cfg.length_offset});
	assign total_rx = {1'b0, rx_byte} + {4'd0, cfg.overhead_length};
	assign reject   = at_len && ((rx_byte > cfg.max_data_length) || (total_rx > 9'd256));
	assign dlen_eff = at_len ? rx_byte : dlen_cur;

	assign crc_pos    = {1'b0, dlen_cur} + {5'd0, cfg.header_length};
	assign crc_pos_p1 = crc_pos + 9'd1;
	assign crc_on     = (idx >= {4'd0, cfg.crc_start}) && (in_hdr || ({1'b0, idx} < crc_pos));

	assign total = {1'b0, dlen_eff} + {4'd0, cfg.overhead_length};

	always_comb begin
		last_pos = (total == 9'd0) ? 9'd0 : total - 9'd1;
		if (last_pos < {5'd0, cfg.length_offset}) begin
			last_pos = {5'd0, cfg.length_offset};
		end
	end

	assign last_reach = !reject && (!in_hdr || at_len) && ({1'b0, idx} >= last_pos);
	assign ends       = reject || last_reach;

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (step) begin
			priority if (!active || ends) begin
				phase_d = PH_HUNT;
			end else if (at_len || !in_hdr) begin
				phase_d = PH_DATA;
			end else begin
				phase_d = PH_HEADER;
			end
		end
	end

	// datapath and result
	always_comb begin
		crc_d    = crc_on ? crc_update(crc_cur, rx_byte) : crc_cur;
		dlen_d   = dlen_eff;
		crc_hi_d = (!in_hdr && ({1'b0, idx} == crc_pos)) ? rx_byte : hi_cur;
		match_d  = match_cur;
		if (!in_hdr && ({1'b0, idx} == crc_pos_p1)) begin
			match_d = (hi_cur == crc_cur[15:8]) && (rx_byte == crc_cur[7:0]);
		end
		count_d = ends ? 8'd0 : idx + 8'd1;

		res.valid      = active;
		res.frame_byte = rx_byte;
		res.byte_index = idx;
		res.frame_last = ends;
		priority if (reject) begin
			res.frame_status = ST_REJECT;
		end else if (last_reach) begin
			res.frame_status = match_d ? ST_GOOD : ST_BAD_CRC;
		end else begin
			res.frame_status = ST_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			dlen_q   <= '0;
			crc_q    <= '0;
			crc_hi_q <= '0;
			match_q  <= 1'b0;
		end else if (step && active) begin
			count_q  <= count_d;
			dlen_q   <= dlen_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
			match_q  <= match_d;
		end
	end

endmodule

>>> sv/crcfd_out_reg.sv
// result register driving the frame channel
// depends on crcfd_pkg and crcfd_frame_if
module crcfd_out_reg
	import crcfd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  res_t           res,
	output logic           advance,
	crcfd_frame_if.source  frame
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic [7:0] index_q;
	logic       last_q;
	status_t    status_q;

	assign advance = !valid_q || frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load && res.valid) begin
			byte_q   <= res.frame_byte;
			index_q  <= res.byte_index;
			last_q   <= res.frame_last;
			status_q <= res.frame_status;
		end
	end

	assign frame.valid        = valid_q;
	assign frame.frame_byte   = byte_q;
	assign frame.byte_index   = index_q;
	assign frame.frame_last   = last_q;
	assign frame.frame_status = status_q;

endmodule

>>> sv/crc16_frame_deframer.sv
// crc16 frame deframer top level: input register, parser, result register
// depends on crcfd_pkg, crcfd_if, crcfd_cfg_regs, crcfd_parser, crcfd_out_reg, assert_macros.svh
//
// channel  dir  request                                   handshake
// rx       in   rx_byte                                   valid / ready
// frame    out  frame_byte, byte_index, frame_last,       valid / ready
//               frame_status
// cfg      in   cfg_index, cfg_wdata                      cfg_we
//
// one byte per cycle unless the frame channel stalls; a taken byte passes the input then the result register
// the running crc update of one byte sits between the input and result registers
// rx.ready falls only while a result waits and frame.ready is low
// reset clears the parse phase and all valid flags; configuration returns to defaults
`include "assert_macros.svh"

module crc16_frame_deframer
	import crcfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	crcfd_rx_if.sink              rx,
	crcfd_frame_if.source         frame,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t       cfg;
	res_t       res;
	logic       advance;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	crcfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign rx.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && rx.valid) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	crcfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (valid_s1 && advance),
		.rx_byte (rx_byte_s1),
		.res     (res)
	);

	crcfd_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (valid_s1),
		.res     (res),
		.advance (advance),
		.frame   (frame)
	);

	`ASSERT_CLK(a_last_status, frame.valid |-> (frame.frame_last == (frame.frame_status != ST_NONE)), "last flag and status disagree")
	`ASSERT_NEVER(a_reject_index, frame.valid && (frame.frame_status == ST_REJECT) && (frame.byte_index > 8'd15), "length rejected beyond length byte range")
	`ASSERT_CLK(a_no_result_unfed, (!valid_s1 && advance) |=> !frame.valid, "result without a byte")

endmodule

>>> tb/tb_top.sv
// self-checking testbench for crc16_frame_deframer: directed frames, then random configurations
// with well-formed, corrupted, cut and rejected frames mixed with line noise
// depends on crcfd_pkg, crcfd_if and the crc16_frame_deframer rtl
module tb_top
	import crcfd_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RESULT_TARGET = 230;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct {
		logic [7:0] fbyte;
		logic [7:0] idx;
		logic       last;
		status_t    status;
	} frame_byte_t;

	class deframer_scoreboard;
		cfg_t        regs = CFG_RESET;
		phase_t      phase = PH_HUNT;
		logic [7:0]  count = 8'd0;
		logic [7:0]  dlen = 8'd0;
		logic [7:0]  crc_hi = 8'd0;
		logic [15:0] crc = 16'h0000;
		bit          crc_ok = 1'b0;
		frame_byte_t frame_bytes_due[$];
		int          errors = 0;
		int          produced = 0;

		static function logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ b[i];
				c = {c[14:0], 1'b0};
				if (fb) begin
					c = c ^ CRC_POLY;
				end
			end
			return c;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_HEAD_VALUE:      regs.head_value = v[7:0];
				REG_LENGTH_OFFSET:   regs.length_offset = v[3:0];
				REG_HEADER_LENGTH:   regs.header_length = v[3:0];
				REG_OVERHEAD_LENGTH: regs.overhead_length = v[4:0];
				REG_MAX_DATA_LENGTH: regs.max_data_length = v[7:0];
				REG_CRC_START:       regs.crc_start = v[3:0];
				REG_CRC_INIT:        regs.crc_init = v;
				default: ;
			endcase
		endfunction

		function void push_due(logic [7:0] b, logic [7:0] i, logic l, status_t s);
			frame_byte_t r;
			r.fbyte = b;
			r.idx = i;
			r.last = l;
			r.status = s;
			frame_bytes_due.push_back(r);
			produced++;
		endfunction

		function void note_rx_byte(logic [7:0] b);
			logic [7:0] idx;
			int total;
			int last;
			int crc_pos;
			if (phase != PH_HEADER && phase != PH_DATA) begin
				phase = PH_HUNT;
				if (b != regs.head_value) begin
					return;
				end
				phase = PH_HEADER;
				count = 8'd0;
				dlen = 8'd0;
				crc = regs.crc_init;
				crc_hi = 8'd0;
				crc_ok = 1'b0;
			end
			idx = count;
			if (phase == PH_HEADER) begin
				if (idx >= regs.crc_start) begin
					crc = crc16_byte(crc, b);
				end
				if (idx != regs.length_offset) begin
					count = idx + 8'd1;
					push_due(b, idx, 1'b0, ST_NONE);
					return;
				end
				dlen = b;
				total = int'(b) + int'(regs.overhead_length);
				if (b > regs.max_data_length || total > 256) begin
					phase = PH_HUNT;
					count = 8'd0;
					push_due(b, idx, 1'b1, ST_REJECT);
					return;
				end
				phase = PH_DATA;
			end else begin
				crc_pos = int'(dlen) + int'(regs.header_length);
				if (idx >= regs.crc_start && int'(idx) < crc_pos) begin
					crc = crc16_byte(crc, b);
				end
				if (int'(idx) == crc_pos) begin
					crc_hi = b;
				end
				if (int'(idx) == crc_pos + 1) begin
					crc_ok = (crc_hi == crc[15:8]) && (b == crc[7:0]);
				end
			end
			// the frame never ends before its length byte
			total = int'(dlen) + int'(regs.overhead_length);
			last = (total > 0) ? total - 1 : 0;
			if (last < int'(regs.length_offset)) begin
				last = int'(regs.length_offset);
			end
			if (int'(idx) >= last) begin
				phase = PH_HUNT;
				count = 8'd0;
				push_due(b, idx, 1'b1, crc_ok ? ST_GOOD : ST_BAD_CRC);
			end else begin
				count = idx + 8'd1;
				push_due(b, idx, 1'b0, ST_NONE);
			end
		endfunction

		function void check_frame_byte(logic [7:0] fb, logic [7:0] i, logic l, logic [1:0] s);
			frame_byte_t e;
			if (frame_bytes_due.size() == 0) begin
				$error("frame byte %0d at index %0d with no request outstanding", fb, i);
				errors++;
				return;
			end
			e = frame_bytes_due.pop_front();
			if (fb !== e.fbyte) begin
				$error("frame_byte: expected %0d, actual %0d", e.fbyte, fb);
				errors++;
			end
			if (i !== e.idx) begin
				$error("byte_index: expected %0d, actual %0d", e.idx, i);
				errors++;
			end
			if (l !== e.last) begin
				$error("frame_last: expected %0d, actual %0d", e.last, l);
				errors++;
			end
			if (s !== e.status) begin
				$error("frame_status: expected %0d, actual %0d", e.status, s);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	bit                    quiet = 1'b0;

	crcfd_rx_if    rx_ch();
	crcfd_frame_if fr_ch();

	deframer_scoreboard sb = new;

	crc16_frame_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.frame     (fr_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 25);
	endfunction

	function automatic cfg_t rand_cfg(bit tidy);
		cfg_t c;
		c.head_value = 8'($urandom());
		c.crc_init = 16'($urandom());
		c.crc_start = 4'($urandom_range(0, 15));
		if (tidy) begin
			// crc bytes land after the length byte and inside the frame
			c.length_offset = 4'($urandom_range(1, 12));
			c.header_length = 4'($urandom_range(c.length_offset + 1, 15));
			c.overhead_length = 5'($urandom_range(c.header_length + 2, c.header_length + 8));
			c.max_data_length = 8'($urandom_range(0, 24));
			if ($urandom_range(0, 1)) begin
				c.crc_start = 4'($urandom_range(0, c.length_offset));
			end
		end else begin
			c.length_offset = 4'($urandom_range(1, 15));
			c.header_length = 4'($urandom_range(1, 15));
			c.overhead_length = 5'($urandom_range(2, 31));
			c.max_data_length = 8'($urandom_range(0, 250));
		end
		return c;
	endfunction

	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		sb.note_rx_byte(b);
	endtask

	task automatic send_frame(int dlen, bit corrupt, bit cut);
		logic [7:0]  fb [0:287];
		cfg_t        g;
		int          n;
		int          total;
		int          crc_pos;
		int          k;
		logic [15:0] c;
		g = sb.regs;
		if (g.length_offset == 0) begin
			dlen = g.head_value;
		end
		total = dlen + g.overhead_length;
		n = (dlen > g.max_data_length || total > 256) ? g.length_offset + 1 : total;
		if (n < g.length_offset + 1) begin
			n = g.length_offset + 1;
		end
		fb[0] = g.head_value;
		for (k = 1; k < n; k++) begin
			fb[k] = 8'($urandom());
		end
		fb[g.length_offset] = 8'(dlen);
		crc_pos = dlen + g.header_length;
		c = g.crc_init;
		for (k = g.crc_start; k < crc_pos && k < n; k++) begin
			c = deframer_scoreboard::crc16_byte(c, fb[k]);
		end
		if (crc_pos > g.length_offset && crc_pos + 1 < n) begin
			fb[crc_pos] = c[15:8];
			fb[crc_pos + 1] = c[7:0];
		end
		if (corrupt && n > 1) begin
			k = $urandom_range(1, n - 1);
			if (k != g.length_offset) begin
				fb[k] = fb[k] ^ 8'(1 << $urandom_range(0, 7));
			end
		end
		if (cut) begin
			n = $urandom_range(1, n);
		end
		for (k = 0; k < n; k++) begin
			send_byte(fb[k]);
		end
	endtask

	task automatic send_noise(int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom());
			if (b == sb.regs.head_value && $urandom_range(0, 3) != 0) begin
				b = ~b;
			end
			send_byte(b);
		end
	endtask

	task automatic settle();
		rx_ch.valid <= 1'b0;
		while (sb.frame_bytes_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apply_config(cfg_t c);
		logic [CFG_IDX_W-1:0]  order [0:7];
		logic [CFG_DATA_W-1:0] v [0:7];
		order = '{REG_HEAD_VALUE, REG_LENGTH_OFFSET, REG_HEADER_LENGTH, REG_OVERHEAD_LENGTH,
			REG_MAX_DATA_LENGTH, REG_CRC_START, REG_CRC_INIT, REG_SPARE};
		// upper bits carry junk that the block must mask off
		for (int i = 0; i < 8; i++) begin
			v[i] = 16'($urandom());
		end
		v[REG_HEAD_VALUE][7:0] = c.head_value;
		v[REG_LENGTH_OFFSET][3:0] = c.length_offset;
		v[REG_HEADER_LENGTH][3:0] = c.header_length;
		v[REG_OVERHEAD_LENGTH][4:0] = c.overhead_length;
		v[REG_MAX_DATA_LENGTH][7:0] = c.max_data_length;
		v[REG_CRC_START][3:0] = c.crc_start;
		v[REG_CRC_INIT] = c.crc_init;
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= order[i];
			cfg_wdata <= v[order[i]];
			@(posedge clk);
			sb.set_reg(order[i], v[order[i]]);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int stall;
		stall = 0;
		fr_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && fr_ch.valid && fr_ch.ready) begin
				sb.check_frame_byte(fr_ch.frame_byte, fr_ch.byte_index, fr_ch.frame_last,
					fr_ch.frame_status);
			end
			if (stall == 0 && !quiet && $urandom_range(0, 99) < 30) begin
				stall = pick_gap();
			end
			fr_ch.ready <= (stall == 0);
			if (stall > 0) begin
				stall--;
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((rx_ch.valid && rx_ch.ready) || (fr_ch.valid && fr_ch.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("[crc16_frame_deframer] ERROR");
		$finish;
	end

	initial begin
		cfg_t c;
		int   start;
		int   lim;
		int   r;
		int   phase_no;
		arst_n <= 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		cfg_we <= 1'b0;
		cfg_index <= REG_HEAD_VALUE;
		cfg_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: noise, good and bad frames, length above maximum
		send_byte(8'hFF);
		send_byte(8'h55);
		send_frame(0, 1'b0, 1'b0);
		send_frame(1, 1'b1, 1'b0);
		send_frame(65, 1'b0, 1'b0);
		send_frame(2, 1'b0, 1'b0);

		// frame longer than the index can count, rejected at its length byte
		settle();
		c = '{head_value: 8'hFF, length_offset: 4'd15, header_length: 4'd15,
			overhead_length: 5'd31, max_data_length: 8'd250, crc_start: 4'd15,
			crc_init: 16'hFFFF};
		apply_config(c);
		send_frame(250, 1'b0, 1'b0);

		// head byte doubles as the length byte
		settle();
		c = '{head_value: 8'd3, length_offset: 4'd0, header_length: 4'd1,
			overhead_length: 5'd3, max_data_length: 8'd250, crc_start: 4'd0,
			crc_init: 16'h0000};
		apply_config(c);
		send_frame(3, 1'b0, 1'b0);

		// frame ends on the length byte, then a zero maximum rejects
		settle();
		c = '{head_value: 8'h80, length_offset: 4'd4, header_length: 4'd1,
			overhead_length: 5'd2, max_data_length: 8'd0, crc_start: 4'd0,
			crc_init: 16'h1D0F};
		apply_config(c);
		send_frame(0, 1'b0, 1'b0);
		send_frame(1, 1'b0, 1'b0);

		phase_no = 0;
		while (sb.produced < RESULT_TARGET) begin
			settle();
			quiet = (phase_no % 4 == 3);
			apply_config(rand_cfg($urandom_range(0, 3) != 0));
			lim = (sb.regs.max_data_length < 16) ? sb.regs.max_data_length : 16;
			start = sb.produced;
			while (sb.produced - start < 40) begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					send_frame($urandom_range(0, lim), $urandom_range(0, 5) == 0, 1'b0);
				end else if (r < 75) begin
					send_frame($urandom_range(sb.regs.max_data_length + 1, 255), 1'b0, 1'b0);
				end else if (r < 85) begin
					send_frame($urandom_range(0, lim), 1'b0, 1'b1);
				end else begin
					send_noise($urandom_range(1, 6));
				end
			end
			phase_no++;
		end

		// one full-size frame: 256 bytes, last index 255
		settle();
		quiet = 1'b0;
		c = '{head_value: 8'($urandom()), length_offset: 4'd2, header_length: 4'd4,
			overhead_length: 5'd6, max_data_length: 8'd250, crc_start: 4'd1,
			crc_init: 16'($urandom())};
		apply_config(c);
		send_frame(250, 1'b0, 1'b0);
		send_noise(4);

		settle();
		if (sb.errors == 0) begin
			$display("[crc16_frame_deframer] OK");
		end else begin
			$display("[crc16_frame_deframer] ERROR");
		end
		$finish;
	end

endmodule

>>> crc16_frame_deframer.f
+incdir+sv
sv/crcfd_pkg.sv
sv/crcfd_if.sv
sv/crcfd_cfg_regs.sv
sv/crcfd_parser.sv
sv/crcfd_out_reg.sv
sv/crc16_frame_deframer.sv
tb/tb_top.sv
